[rtl/core/ltc_pkg.sv]
// Shared types, codes and helpers for the logic trigger capture block.
`timescale 1ns / 1ps

package ltc_pkg;

  // Fixed field widths of the stream beats.
  localparam int unsigned SAMPLE_W   = 4;
  localparam int unsigned INDEX_W    = 7;
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 8;

  // Default build parameters.
  localparam int unsigned DEF_MAX_SAMPLES = 128;
  localparam int unsigned DEF_CHANNELS    = 4;

  // Item opcodes.
  localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ARM  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_CHANNEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_SAMPLES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_SAMPLES    = 3'd5;

  // Trigger modes.
  localparam logic [1:0] TRIG_RISING  = 2'd0;
  localparam logic [1:0] TRIG_FALLING = 2'd1;
  localparam logic [1:0] TRIG_ANY     = 2'd2;
  localparam logic [1:0] TRIG_I2C     = 2'd3;

  // Reported phase codes.
  localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_WAIT    = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_COLLECT = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_DONE    = 2'd3;

  // Capture state machine, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_WAIT    = 4'b0010,
    ST_COLLECT = 4'b0100,
    ST_DONE    = 4'b1000
  } cap_state_e;

  // Result of one item as it leaves the control logic.
  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic                from_mem;
    logic [SAMPLE_W-1:0] data;
  } ltc_resp_t;

  // Phase code reported for a capture state.
  function automatic logic [PHASE_W-1:0] phase_code(cap_state_e st);
    logic [PHASE_W-1:0] code;
    unique case (st)
      ST_IDLE:    code = PHASE_IDLE;
      ST_WAIT:    code = PHASE_WAIT;
      ST_COLLECT: code = PHASE_COLLECT;
      ST_DONE:    code = PHASE_DONE;
      default:    code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/ltc_ring.sv]
// Sample ring memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module ltc_ring #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ltc_ctrl.sv]
// Capture control: configuration, trigger qualification, ring addressing.
`timescale 1ns / 1ps

module ltc_ctrl #(
  parameter int unsigned MAX_SAMPLES = 128,
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned AW          = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ltc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ltc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             accept_i,
  input  logic [ltc_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic [ltc_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic [ltc_pkg::INDEX_W-1:0]      read_index_i,
  output logic                             ring_we_o,
  output logic [AW-1:0]                    ring_waddr_o,
  output logic [ltc_pkg::SAMPLE_W-1:0]     ring_wdata_o,
  output logic                             ring_re_o,
  output logic [AW-1:0]                    ring_raddr_o,
  output ltc_pkg::ltc_resp_t               resp_o
);

  import ltc_pkg::*;

  localparam int unsigned CW       = $clog2(MAX_SAMPLES + 1);
  localparam logic [31:0] MAX32    = 32'(MAX_SAMPLES);
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_SAMPLES);
  localparam logic [AW-1:0] WP_LAST = AW'(MAX_SAMPLES - 1);
  localparam logic [RUN_W-1:0] RUN_MAX  = {RUN_W{1'b1}};
  localparam logic [RUN_W-1:0] RUN_INIT =
    (MAX_SAMPLES > 255) ? RUN_MAX : RUN_W'(MAX_SAMPLES);

  // Configuration registers.
  logic                  capture_mode_q;
  logic [1:0]            trigger_mode_q;
  logic [1:0]            trigger_channel_q;
  logic [INDEX_W-1:0]    pre_samples_q;
  logic [7:0]            total_samples_q;
  logic [7:0]            idle_samples_q;

  // Capture state.
  cap_state_e            state_q, state_d;
  logic [CW-1:0]         frame_total_q, frame_total_d;
  logic [CW-1:0]         tail_q, tail_d;
  logic [1:0]            armed_mode_q, armed_mode_d;
  logic [SAMPLE_W-1:0]   armed_mask_q, armed_mask_d;
  logic [SAMPLE_W-1:0]   prefill_q, prefill_d;
  logic [SAMPLE_W-1:0]   prev_q, prev_d;
  logic [AW-1:0]         wp_q, wp_d;
  logic [CW-1:0]         wcount_q, wcount_d;
  logic [CW-1:0]         post_q, post_d;
  logic [RUN_W-1:0]      stable_q, stable_d;
  logic [RUN_W-1:0]      bus_idle_q, bus_idle_d;

  logic [SAMPLE_W-1:0]   ch_mask;
  logic [SAMPLE_W-1:0]   smp;
  logic [CW-1:0]         t_eff;
  logic [CW-1:0]         p_eff;
  logic                  trig;
  logic                  edge_hit;
  logic                  last_lvl;
  logic                  now_lvl;
  logic                  same_lvl;
  logic                  store;
  logic [CW-1:0]         age;
  logic [CW:0]           pdiff;
  logic [CW:0]           pwrap;
  logic                  in_frame;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_mode_q    <= 1'b1;
      trigger_mode_q    <= TRIG_ANY;
      trigger_channel_q <= 2'd0;
      pre_samples_q     <= INDEX_W'(16);
      total_samples_q   <= 8'd64;
      idle_samples_q    <= 8'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAPTURE_MODE:    capture_mode_q    <= cfg_data_i[0];
        REG_TRIGGER_MODE:    trigger_mode_q    <= cfg_data_i[1:0];
        REG_TRIGGER_CHANNEL: trigger_channel_q <= cfg_data_i[1:0];
        REG_PRE_SAMPLES:     pre_samples_q     <= cfg_data_i[INDEX_W-1:0];
        REG_TOTAL_SAMPLES:   total_samples_q   <= cfg_data_i;
        REG_IDLE_SAMPLES:    idle_samples_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Channels that exist in this build.
  always_comb begin
    for (int i = 0; i < int'(SAMPLE_W); i++) begin
      ch_mask[i] = (i < int'(CHANNELS));
    end
  end

  assign smp = sample_i & ch_mask;

  // Frame length and pretrigger count as latched at arm.
  always_comb begin
    if (total_samples_q == 8'd0 || 32'(total_samples_q) > MAX32) begin
      t_eff = MAX_CW;
    end else begin
      t_eff = CW'(total_samples_q);
    end
    if (32'(pre_samples_q) >= 32'(t_eff)) begin
      p_eff = t_eff >> 2;
    end else begin
      p_eff = CW'(pre_samples_q);
    end
  end

  // Trigger qualification against the previous sample and the run counters.
  always_comb begin
    last_lvl = |(prev_q & armed_mask_q);
    now_lvl  = |(smp & armed_mask_q);
    same_lvl = ((smp ^ prev_q) & armed_mask_q) == '0;
    case (armed_mode_q)
      TRIG_RISING:  edge_hit = !last_lvl && now_lvl;
      TRIG_FALLING: edge_hit = last_lvl && !now_lvl;
      default:      edge_hit = last_lvl != now_lvl;
    endcase
    if (armed_mode_q == TRIG_I2C) begin
      trig = (prev_q[1:0] == 2'b11) && smp[0] && !smp[1] &&
             (bus_idle_q >= idle_samples_q);
    end else begin
      trig = edge_hit && (stable_q >= idle_samples_q);
    end
  end

  // Frame read address: entry k sits T-1-k samples back from the newest one.
  always_comb begin
    in_frame = 32'(read_index_i) < 32'(frame_total_q);
    age      = frame_total_q - CW'(read_index_i);
    pdiff    = (CW + 1)'(wp_q) - (CW + 1)'(age);
    pwrap    = pdiff[CW] ? pdiff + (CW + 1)'(MAX_SAMPLES) : pdiff;
  end

  assign ring_raddr_o = AW'(pwrap);

  // Next state for one accepted item.
  always_comb begin
    state_d       = state_q;
    frame_total_d = frame_total_q;
    tail_d        = tail_q;
    armed_mode_d  = armed_mode_q;
    armed_mask_d  = armed_mask_q;
    prefill_d     = prefill_q;
    prev_d        = prev_q;
    wp_d          = wp_q;
    wcount_d      = wcount_q;
    post_d        = post_q;
    stable_d      = stable_q;
    bus_idle_d    = bus_idle_q;
    store         = 1'b0;
    ring_re_o     = 1'b0;
    resp_o        = '0;

    if (accept_i) begin
      unique case (opcode_i)
        OP_ARM: begin
          frame_total_d = t_eff;
          armed_mode_d  = trigger_mode_q;
          armed_mask_d  = '0;
          if (32'(trigger_channel_q) < 32'(CHANNELS)) begin
            armed_mask_d[trigger_channel_q] = 1'b1;
          end
          prefill_d = smp;
          prev_d    = smp;
          wp_d      = '0;
          wcount_d  = '0;
          post_d    = '0;
          if (capture_mode_q) begin
            state_d    = ST_WAIT;
            tail_d     = t_eff - p_eff;
            stable_d   = RUN_INIT;
            bus_idle_d = (smp[1:0] == 2'b11) ? RUN_INIT : '0;
          end else begin
            state_d = ST_COLLECT;
            tail_d  = t_eff;
          end
        end
        OP_TICK: begin
          if (state_q == ST_WAIT) begin
            store      = 1'b1;
            stable_d   = same_lvl ? ((stable_q == RUN_MAX) ? RUN_MAX : stable_q + 1'b1)
                                  : RUN_W'(1);
            bus_idle_d = (smp[1:0] == 2'b11)
                       ? ((bus_idle_q == RUN_MAX) ? RUN_MAX : bus_idle_q + 1'b1)
                       : '0;
            prev_d     = smp;
            if (trig) begin
              post_d  = CW'(1);
              state_d = (CW'(1) >= tail_q) ? ST_DONE : ST_COLLECT;
            end
          end else if (state_q == ST_COLLECT) begin
            store  = 1'b1;
            post_d = (32'(post_q) < MAX32) ? post_q + 1'b1 : post_q;
            if (post_d >= tail_q) begin
              state_d = ST_DONE;
            end
          end
        end
        OP_READ: begin
          if (state_q == ST_DONE && in_frame) begin
            if (32'(age) > 32'(wcount_q)) begin
              resp_o.data = prefill_q;
            end else begin
              ring_re_o       = 1'b1;
              resp_o.from_mem = 1'b1;
            end
          end
        end
        default: ;
      endcase

      // Ring pointer and fill count advance on every stored sample.
      if (store) begin
        wp_d     = (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
        wcount_d = (32'(wcount_q) < MAX32) ? wcount_q + 1'b1 : wcount_q;
      end
      resp_o.phase = phase_code(state_d);
    end
  end

  assign ring_we_o    = store;
  assign ring_waddr_o = wp_q;
  assign ring_wdata_o = smp;

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_total_q <= MAX_CW;
      tail_q        <= MAX_CW;
      armed_mode_q  <= TRIG_ANY;
      armed_mask_q  <= SAMPLE_W'(1);
      prefill_q     <= '0;
      prev_q        <= '0;
      wp_q          <= '0;
      wcount_q      <= '0;
      post_q        <= '0;
      stable_q      <= '0;
      bus_idle_q    <= '0;
    end else begin
      state_q       <= state_d;
      frame_total_q <= frame_total_d;
      tail_q        <= tail_d;
      armed_mode_q  <= armed_mode_d;
      armed_mask_q  <= armed_mask_d;
      prefill_q     <= prefill_d;
      prev_q        <= prev_d;
      wp_q          <= wp_d;
      wcount_q      <= wcount_d;
      post_q        <= post_d;
      stable_q      <= stable_d;
      bus_idle_q    <= bus_idle_d;
    end
  end

endmodule

[rtl/core/logic_trigger_capture.sv]
// Top level of the logic trigger capture block: stream ports and result pipeline.
`timescale 1ns / 1ps

// The block accepts one beat per clock cycle unless the output side stalls:
// sample ticks, arms and frame reads may follow each other back to back. Each
// beat gives exactly one result beat, which passes the in-flight register and
// then the output register before it leaves. The extra stage is set by the
// single registered read port of the sample ring; a read and a write never
// fall on the same cycle since each beat does at most one of them. A stall on
// the output side holds one result in the output register and one in flight,
// after which the input side stalls too. No clearing pass follows reset.

module logic_trigger_capture #(
  parameter int unsigned MAX_SAMPLES = ltc_pkg::DEF_MAX_SAMPLES,
  parameter int unsigned CHANNELS    = ltc_pkg::DEF_CHANNELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [ltc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ltc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Item stream in.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ltc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // sample[3:0], read_index[10:4]
  input  logic [ltc_pkg::OPCODE_W-1:0]      s_axis_tuser,  // opcode[1:0]
  // Result stream out.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ltc_pkg::M_TDATA_W-1:0]     m_axis_tdata   // phase[1:0], read_data[5:2]
);

  import ltc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SAMPLES);

  logic                 accept;
  logic                 advance;
  logic                 ring_we;
  logic [AW-1:0]        ring_waddr;
  logic [SAMPLE_W-1:0]  ring_wdata;
  logic                 ring_re;
  logic [AW-1:0]        ring_raddr;
  logic [SAMPLE_W-1:0]  ring_rdata;
  ltc_resp_t            resp;
  ltc_resp_t            s1_q;
  logic                 s1_valid_q;
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [SAMPLE_W-1:0]  s1_data;

  // Handshake: the in-flight stage frees up whenever the output can move.
  assign s_axis_tready = !s1_valid_q || !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);

  ltc_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CHANNELS    (CHANNELS),
    .AW          (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .opcode_i     (s_axis_tuser),
    .sample_i     (s_axis_tdata[SAMPLE_W-1:0]),
    .read_index_i (s_axis_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W]),
    .ring_we_o    (ring_we),
    .ring_waddr_o (ring_waddr),
    .ring_wdata_o (ring_wdata),
    .ring_re_o    (ring_re),
    .ring_raddr_o (ring_raddr),
    .resp_o       (resp)
  );

  ltc_ring #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW),
    .DW    (SAMPLE_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Stage one waits for the ring read; pick ring data or the held value.
  assign s1_data = s1_q.from_mem ? ring_rdata : s1_q.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= resp;
    end
    if (advance) begin
      out_data_q <= {(M_TDATA_W - PHASE_W - SAMPLE_W)'(0), s1_data, s1_q.phase};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[tb/sv/capture_frame_checker.sv]
// Checker for the logic trigger capture block: predicts every result beat and compares it.
`timescale 1ns / 1ps

module capture_frame_checker
  import ltc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // sample[3:0], read_index[10:4]
  input  logic [OPCODE_W-1:0]   s_axis_tuser,  // opcode[1:0]
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,  // phase[1:0], read_data[5:2]
  output int                    mismatches_o,
  output int                    outstanding_o,
  output logic [PHASE_W-1:0]    phase_o,
  output int                    triggers_o,
  output int                    frame_reads_o
);

  localparam int unsigned RING_DEPTH = DEF_MAX_SAMPLES;
  localparam logic [RUN_W-1:0] RUN_SAT = 8'hFF;
  // The arm prefill counts as a full ring of history, capped at saturation.
  localparam logic [RUN_W-1:0] RUN_PREFILL = RUN_W'((RING_DEPTH > 255) ? 255 : RING_DEPTH);

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [SAMPLE_W-1:0] data;
  } capture_status_t;

  // Results owed by the block, oldest first.
  capture_status_t status_due[$];

  // Register copies.
  logic                cfg_capture;
  logic [1:0]          cfg_trig_mode;
  logic [1:0]          cfg_channel;
  logic [6:0]          cfg_pre;
  logic [7:0]          cfg_total;
  logic [7:0]          cfg_idle;

  // Capture state.
  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [INDEX_W-1:0]  wr_ptr;
  logic [7:0]          wr_count;
  logic [SAMPLE_W-1:0] prefill;
  logic [PHASE_W-1:0]  cur_phase;
  logic [SAMPLE_W-1:0] prev_smp;
  logic [RUN_W-1:0]    stable_run;
  logic [RUN_W-1:0]    bus_run;
  logic [7:0]          post_count;

  // Settings latched at arm.
  int unsigned         frame_len;
  int unsigned         frame_pre;
  logic [1:0]          armed_mode;
  logic [SAMPLE_W-1:0] armed_mask;

  int errors;
  int trig_count;
  int in_frame_reads;

  task automatic clear_state();
    cfg_capture    = 1'b1;
    cfg_trig_mode  = TRIG_ANY;
    cfg_channel    = 2'd0;
    cfg_pre        = 7'd16;
    cfg_total      = 8'd64;
    cfg_idle       = 8'd8;
    wr_ptr         = '0;
    wr_count       = '0;
    prefill        = '0;
    cur_phase      = PHASE_IDLE;
    prev_smp       = '0;
    stable_run     = '0;
    bus_run        = '0;
    post_count     = '0;
    frame_len      = RING_DEPTH;
    frame_pre      = 0;
    armed_mode     = TRIG_ANY;
    armed_mask     = 4'b0001;
    errors         = 0;
    trig_count     = 0;
    in_frame_reads = 0;
    status_due.delete();
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CAPTURE_MODE:    cfg_capture   = val[0];
      REG_TRIGGER_MODE:    cfg_trig_mode = val[1:0];
      REG_TRIGGER_CHANNEL: cfg_channel   = val[1:0];
      REG_PRE_SAMPLES:     cfg_pre       = val[6:0];
      REG_TOTAL_SAMPLES:   cfg_total     = val;
      REG_IDLE_SAMPLES:    cfg_idle      = val;
      default: ;
    endcase
  endtask

  task automatic store_sample(input logic [SAMPLE_W-1:0] smp);
    ring[wr_ptr] = smp;
    wr_ptr = wr_ptr + 1'b1;
    if (wr_count < RING_DEPTH) wr_count = wr_count + 1'b1;
  endtask

  // Advances the capture by one input beat and queues the status it yields.
  task automatic capture_step(input logic [OPCODE_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                              input logic [INDEX_W-1:0] idx);
    capture_status_t    st;
    logic               last_lvl;
    logic               now_lvl;
    logic               edge_seen;
    logic               fire;
    int unsigned        age;
    logic [INDEX_W-1:0] pos;
    st.data = '0;
    case (op)
      OP_ARM: begin
        frame_len  = (cfg_total == 0 || cfg_total > RING_DEPTH) ? RING_DEPTH : cfg_total;
        frame_pre  = (cfg_pre >= frame_len) ? frame_len / 4 : cfg_pre;
        armed_mode = cfg_trig_mode;
        armed_mask = 4'b0001 << cfg_channel;
        prefill    = smp;
        prev_smp   = smp;
        wr_ptr     = '0;
        wr_count   = '0;
        post_count = '0;
        if (cfg_capture) begin
          cur_phase  = PHASE_WAIT;
          stable_run = RUN_PREFILL;
          bus_run    = (smp[1:0] == 2'b11) ? RUN_PREFILL : '0;
        end else begin
          frame_pre = 0;
          cur_phase = PHASE_COLLECT;
        end
      end
      OP_TICK: begin
        if (cur_phase == PHASE_WAIT) begin
          // Qualify the trigger against the history before this sample.
          last_lvl = |(prev_smp & armed_mask);
          now_lvl  = |(smp & armed_mask);
          if (armed_mode == TRIG_I2C) begin
            fire = (prev_smp[1:0] == 2'b11) && (smp[1:0] == 2'b01) && (bus_run >= cfg_idle);
          end else begin
            case (armed_mode)
              TRIG_RISING:  edge_seen = !last_lvl && now_lvl;
              TRIG_FALLING: edge_seen = last_lvl && !now_lvl;
              default:      edge_seen = last_lvl != now_lvl;
            endcase
            fire = edge_seen && (stable_run >= cfg_idle);
          end
          stable_run = (last_lvl == now_lvl) ?
                       ((stable_run == RUN_SAT) ? RUN_SAT : stable_run + 1'b1) : 8'd1;
          bus_run    = (smp[1:0] != 2'b11) ? '0 :
                       ((bus_run == RUN_SAT) ? RUN_SAT : bus_run + 1'b1);
          prev_smp   = smp;
          store_sample(smp);
          if (fire) begin
            trig_count++;
            post_count = 8'd1;
            cur_phase  = (post_count >= frame_len - frame_pre) ? PHASE_DONE : PHASE_COLLECT;
          end
        end else if (cur_phase == PHASE_COLLECT) begin
          store_sample(smp);
          if (post_count < RING_DEPTH) post_count = post_count + 1'b1;
          if (post_count >= frame_len - frame_pre) cur_phase = PHASE_DONE;
        end
      end
      OP_READ: begin
        if (cur_phase == PHASE_DONE && idx < frame_len) begin
          in_frame_reads++;
          age = frame_len - idx;
          // Positions older than anything written read back as the prefill.
          if (age > wr_count) begin
            st.data = prefill;
          end else begin
            pos     = wr_ptr - INDEX_W'(age);
            st.data = ring[pos];
          end
        end
      end
      default: ;
    endcase
    st.phase = cur_phase;
    status_due.push_back(st);
  endtask

  task automatic check_result(input logic [M_TDATA_W-1:0] beat);
    capture_status_t want;
    if (status_due.size() == 0) begin
      if (errors < 10) $display("Unexpected result beat 0x%02h with nothing owed", beat);
      errors++;
    end else begin
      want = status_due.pop_front();
      if (beat[1:0] !== want.phase || beat[5:2] !== want.data) begin
        if (errors < 10) begin
          $display("Result mismatch: phase %0d data 0x%0h, expected phase %0d data 0x%0h",
                   beat[1:0], beat[5:2], want.phase, want.data);
        end
        errors++;
      end
    end
  endtask

  // Registers before items, results checked before the new beat is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        capture_step(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[10:4]);
      end
    end
    mismatches_o  <= errors;
    outstanding_o <= status_due.size();
    phase_o       <= cur_phase;
    triggers_o    <= trig_count;
    frame_reads_o <= in_frame_reads;
  end

endmodule

[tb/sv/logic_trigger_capture_tb.sv]
// Testbench top for the logic trigger capture block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module logic_trigger_capture_tb;
  import ltc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int RING_DEPTH  = DEF_MAX_SAMPLES;

  typedef enum int {
    PACE_STEADY,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // sample[3:0], read_index[10:4]
  logic [OPCODE_W-1:0]   s_axis_tuser  = '0;  // opcode[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // phase[1:0], read_data[5:2]

  int                    mismatches;
  int                    outstanding;
  logic [PHASE_W-1:0]    phase;
  int                    triggers;
  int                    frame_reads;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left_rx   = 0;
  int quiet_cycles   = 0;
  int items_sent     = 0;
  int settings_used  = 0;

  // Sample pattern state: levels held for runs around the idle requirement.
  logic [1:0]          gen_mode;
  logic [1:0]          gen_chan;
  int                  gen_idle;
  int                  gen_len;
  logic [SAMPLE_W-1:0] hold_val;
  int                  hold_left;

  always #5 clk = ~clk;

  logic_trigger_capture dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  capture_frame_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .phase_o       (phase),
    .triggers_o    (triggers),
    .frame_reads_o (frame_reads)
  );

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left_rx = hold_req;
      hold_req = 0;
    end
    if (hold_left_rx != 0) begin
      hold_left_rx--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one beat and returns at the edge that accepts it, valid still high.
  task automatic offer(input logic [OPCODE_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                       input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= S_TDATA_W'({idx, smp});
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stops offering and waits until every owed result has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic cap, input logic [1:0] tmode, input logic [1:0] chan,
                           input logic [6:0] pre, input logic [7:0] total,
                           input logic [7:0] idle);
    write_reg(REG_CAPTURE_MODE, CFG_DATA_W'(cap));
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(tmode));
    write_reg(REG_TRIGGER_CHANNEL, CFG_DATA_W'(chan));
    write_reg(REG_PRE_SAMPLES, CFG_DATA_W'(pre));
    write_reg(REG_TOTAL_SAMPLES, total);
    write_reg(REG_IDLE_SAMPLES, idle);
    cfg_we_i <= 1'b0;
    gen_mode = tmode;
    gen_chan = chan;
    gen_idle = idle;
    gen_len  = (total == 0 || total > RING_DEPTH) ? RING_DEPTH : total;
    settings_used++;
  endtask

  task automatic start_pattern(input logic [SAMPLE_W-1:0] arm_val);
    hold_val  = arm_val;
    hold_left = $urandom_range(gen_idle + 2);
  endtask

  // Next tick sample: bus lines and the watched channel hold their level for a
  // run, the other channels toggle freely.
  function automatic logic [SAMPLE_W-1:0] next_level();
    logic [SAMPLE_W-1:0] keep;
    logic [SAMPLE_W-1:0] noise;
    logic [SAMPLE_W-1:0] fresh;
    keep  = 4'b0011 | (4'b0001 << gen_chan);
    noise = SAMPLE_W'($urandom);
    fresh = SAMPLE_W'($urandom);
    if (hold_left == 0) begin
      if (gen_mode == TRIG_I2C) begin
        // Start conditions mostly follow a stretch of idle bus.
        if (hold_val[1:0] == 2'b11 && $urandom_range(1) == 1) begin
          hold_val = {fresh[3:2], 2'b01};
        end else if ($urandom_range(9) < 6) begin
          hold_val = {fresh[3:2], 2'b11};
        end else begin
          hold_val = fresh;
        end
      end else begin
        if ($urandom_range(4) != 0) fresh[gen_chan] = ~hold_val[gen_chan];
        hold_val = fresh;
      end
      hold_left = ($urandom_range(3) == 0) ? $urandom_range(gen_idle) + 1 :
                  gen_idle + 1 + $urandom_range(4);
    end
    hold_left--;
    return (hold_val & keep) | (noise & ~keep);
  endfunction

  // Noise inside a capture: early reads, unused opcodes and re-arms.
  task automatic stray_item();
    logic [SAMPLE_W-1:0] arm_val;
    arm_val = SAMPLE_W'($urandom);
    case ($urandom_range(2))
      0: offer(OP_READ, SAMPLE_W'($urandom), INDEX_W'($urandom));
      1: offer(OP_UNUSED, SAMPLE_W'($urandom), INDEX_W'($urandom));
      default: begin
        start_pattern(arm_val);
        offer(OP_ARM, arm_val, INDEX_W'($urandom));
      end
    endcase
  endtask

  // One capture: arm, ticks until the frame is done, then reads of the frame.
  task automatic capture_run();
    logic [SAMPLE_W-1:0] arm_val;
    int                  ticks;
    int                  tick_cap;
    arm_val = SAMPLE_W'($urandom);
    if (gen_mode == TRIG_I2C && $urandom_range(1) == 1) arm_val[1:0] = 2'b11;
    start_pattern(arm_val);
    offer(OP_ARM, arm_val, INDEX_W'($urandom));
    tick_cap = 2 * gen_len + 2 * gen_idle + 40;
    ticks = 0;
    // The predicted phase seen here lags the last accepted beat by one.
    while ((ticks == 0 || phase != PHASE_DONE) && ticks < tick_cap) begin
      if ($urandom_range(39) == 0) begin
        stray_item();
      end else begin
        offer(OP_TICK, next_level(), INDEX_W'($urandom));
        ticks++;
      end
    end
    repeat ($urandom_range(4, 12)) begin
      offer(OP_READ, SAMPLE_W'($urandom), ($urandom_range(2) != 0) ?
            INDEX_W'($urandom_range(gen_len - 1)) : INDEX_W'($urandom));
    end
    if ($urandom_range(3) == 0) offer(OP_TICK, SAMPLE_W'($urandom), INDEX_W'($urandom));
  endtask

  task automatic random_phase(input logic cap, input logic [1:0] tmode, input logic [1:0] chan,
                              input logic [6:0] pre, input logic [7:0] total,
                              input logic [7:0] idle, input int budget, input pace_e pace,
                              input bit squeeze);
    int  start;
    bit  paused;
    settle();
    configure(cap, tmode, chan, pre, total, idle);
    case (pace)
      PACE_STEADY:         begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER_IDLE:    begin send_idle_pct = 62; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default:             begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
    // A long hold-off lets the block back up and stall its input.
    if (squeeze) hold_req = HOLD_CYCLES;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < budget) begin
      capture_run();
      if (!paused && items_sent - start >= budget / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: read while idle, ignored tick, unused opcode.
    offer(OP_READ, 4'h0, 7'd0);
    offer(OP_TICK, 4'hF, 7'd0);
    offer(OP_UNUSED, 4'h0, 7'h7F);

    // Normal capture of two samples, reads inside and outside the frame,
    // an ignored tick after the frame and a re-arm while collecting.
    settle();
    configure(1'b0, TRIG_RISING, 2'd3, 7'd0, 8'd2, 8'd0);
    offer(OP_ARM, 4'hF, 7'd0);
    offer(OP_TICK, 4'h0, 7'd0);
    offer(OP_TICK, 4'hF, 7'd0);
    offer(OP_READ, 4'h0, 7'd0);
    offer(OP_READ, 4'h0, 7'd1);
    offer(OP_READ, 4'h0, 7'h7F);
    offer(OP_TICK, 4'h5, 7'd0);
    offer(OP_ARM, 4'h5, 7'd0);
    offer(OP_TICK, 4'hA, 7'd0);
    offer(OP_ARM, 4'h3, 7'd0);
    offer(OP_READ, 4'h0, 7'd0);

    // Falling trigger with pre_samples too large: the frame reaches back past
    // the first stored sample and reads the prefill.
    settle();
    configure(1'b1, TRIG_FALLING, 2'd1, 7'd127, 8'd4, 8'd0);
    offer(OP_ARM, 4'h2, 7'd0);
    offer(OP_TICK, 4'h0, 7'd0);
    offer(OP_TICK, 4'hF, 7'd0);
    offer(OP_TICK, 4'h1, 7'd0);
    offer(OP_READ, 4'h0, 7'd0);

    // I2C start where the trigger sample alone completes the frame.
    settle();
    configure(1'b1, TRIG_I2C, 2'd0, 7'd3, 8'd4, 8'd2);
    offer(OP_ARM, 4'h3, 7'd0);
    offer(OP_TICK, 4'h1, 7'd0);
    offer(OP_READ, 4'h0, 7'd0);
    offer(OP_READ, 4'h0, 7'd3);

    // Random captures under a range of settings and traffic patterns.
    random_phase(1'b1, TRIG_ANY,     2'd0, 7'd16,  8'd64,  8'd8,   90, PACE_STEADY,         1'b1);
    random_phase(1'b1, TRIG_RISING,  2'd2, 7'd3,   8'd16,  8'd4,   90, PACE_SENDER_IDLE,    1'b0);
    random_phase(1'b1, TRIG_FALLING, 2'd3, 7'd0,   8'd8,   8'd0,   90, PACE_RECEIVER_STALL, 1'b0);
    random_phase(1'b0, TRIG_ANY,     2'd0, 7'd0,   8'd1,   8'd0,   80, PACE_BOTH,           1'b0);
    random_phase(1'b1, TRIG_I2C,     2'd0, 7'd2,   8'd12,  8'd3,   90, PACE_STEADY,         1'b1);
    random_phase(1'b1, TRIG_ANY,     2'd1, 7'd127, 8'd128, 8'd128, 1,  PACE_SENDER_IDLE,    1'b0);
    random_phase(1'b0, TRIG_RISING,  2'd0, 7'd10,  8'd0,   8'd5,   1,  PACE_RECEIVER_STALL, 1'b0);
    random_phase(1'b1, TRIG_RISING,  2'd0, 7'd5,   8'd200, 8'd255, 1,  PACE_BOTH,           1'b0);
    random_phase(1'b1, TRIG_I2C,     2'd3, 7'd6,   8'd20,  8'd10,  90, PACE_STEADY,         1'b0);
    random_phase(1'b1, TRIG_FALLING, 2'd2, 7'd9,   8'd24,  8'd2,   90, PACE_RECEIVER_STALL, 1'b0);
    random_phase(1'b0, TRIG_FALLING, 2'd1, 7'd100, 8'd10,  8'd1,   80, PACE_SENDER_IDLE,    1'b0);
    random_phase(1'b1, TRIG_ANY,     2'd3, 7'd1,   8'd2,   8'd1,   90, PACE_BOTH,           1'b0);
    random_phase(1'b1, TRIG_I2C,     2'd2, 7'd0,   8'd6,   8'd0,   80, PACE_STEADY,         1'b0);

    settle();
    repeat (4) @(posedge clk);

    $display("Run covered %0d input beats under %0d register settings with %0d triggers,",
             items_sent, settings_used, triggers);
    $display("%0d reads inside a finished frame and %0d results left owed.",
             frame_reads, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
